@@ rtl/metronome_click_generator_unit_macros.svh @@
// ----------------------------------------------------------------------------
// metronome click generator assertion macros
// shared property shapes for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef METRONOME_CLICK_GENERATOR_UNIT_MACROS_SVH
`define METRONOME_CLICK_GENERATOR_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define MCG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcg assertion failed");

// consequent must hold in the cycle after the antecedent
`define MCG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcg assertion failed");

`endif

@@ rtl/mcg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_pkg
// types and constants shared by the metronome click generator modules
// ----------------------------------------------------------------------------
package mcg_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEATS_PER_MEASURE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEAT_SAMPLES      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TONE_SAMPLES      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAVEFORM          = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCENT_STEP       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORMAL_STEP       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_IN_GAIN      = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_OUT_GAIN     = 3'd7;

   localparam int CSR_DATA_W   = 32;
   localparam int BEATS_CFG_W  = 6;
   localparam int LEN_CFG_W    = 24;
   localparam int PHASE_W      = 32;
   localparam int GAIN_W       = 25;
   localparam int SAMPLE_W     = 16;
   localparam int WAVE_MAG_W   = 15;
   localparam int GAIN_FRAC_W  = 24;

   localparam logic [GAIN_W-1:0]     ONE_Q24    = 25'h100_0000;
   localparam logic [WAVE_MAG_W-1:0] FULL_SCALE = 15'd32767;

   // reset values of the configuration registers
   localparam logic [BEATS_CFG_W-1:0] RST_BEATS_PER_MEASURE = 6'd4;
   localparam logic [LEN_CFG_W-1:0]   RST_BEAT_SAMPLES      = 24'd22050;
   localparam logic [LEN_CFG_W-1:0]   RST_TONE_SAMPLES      = 24'd1764;
   localparam logic [PHASE_W-1:0]     RST_ACCENT_STEP       = 32'd50960;
   localparam logic [PHASE_W-1:0]     RST_NORMAL_STEP       = 32'd25480;
   localparam logic [GAIN_W-1:0]      RST_FADE_IN_GAIN      = 25'd9511;
   localparam logic [GAIN_W-1:0]      RST_FADE_OUT_GAIN     = 25'd3804;

   // sine table build: pi/2 in Q30 and the taylor term divisors (2n)(2n+1)
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
   localparam int SINE_TERMS = 13;
   localparam logic [9:0] TERM_DIV [1:SINE_TERMS] = '{
      10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156, 10'd210,
      10'd272, 10'd342, 10'd420, 10'd506, 10'd600, 10'd702
   };

   // serial multiplier geometry
   localparam int MUL_A_W   = 24;
   localparam int MUL_B_W   = 25;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROM,
      ST_WAVE,
      ST_GAIN_MUL,
      ST_MAG_START,
      ST_MAG_MUL,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      ENV_SILENT,
      ENV_FADE_IN,
      ENV_FADE_OUT,
      ENV_FULL
   } env_region_type;

   typedef enum logic [1:0] {
      WAVE_SINE,
      WAVE_SQUARE,
      WAVE_SAW,
      WAVE_TRIANGLE
   } waveform_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage

@@ rtl/mcg_serial_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_serial_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module mcg_serial_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  mcg_pkg::mul_cmd_type         cmd,
   output mcg_pkg::mul_status_type      status,
   output logic [mcg_pkg::MUL_P_W-1:0]  product
);

   localparam int A_W = mcg_pkg::MUL_A_W;
   localparam int B_W = mcg_pkg::MUL_B_W;

   logic [A_W-1:0]                  a_ff;
   logic [B_W-1:0]                  b_ff;
   logic [A_W-1:0]                  hi_ff;
   logic [B_W-1:0]                  lo_ff;
   logic [mcg_pkg::MUL_CNT_W-1:0]   cnt_ff;
   logic                            done_ff;
   logic                            busy;
   logic [A_W:0]                    partial_sum;

   assign busy = (cnt_ff != '0);

   // upper half accumulates, low product bits fall out into lo_ff
   assign partial_sum = {1'b0, hi_ff} + (b_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (cmd.start) begin
         cnt_ff  <= mcg_pkg::MUL_CNT_W'(B_W);
         done_ff <= 1'b0;
      end else if (busy) begin
         cnt_ff  <= cnt_ff - mcg_pkg::MUL_CNT_W'(1);
         done_ff <= (cnt_ff == mcg_pkg::MUL_CNT_W'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         a_ff  <= cmd.a;
         b_ff  <= cmd.b;
         hi_ff <= '0;
      end else if (busy) begin
         hi_ff <= partial_sum[A_W:1];
         lo_ff <= {partial_sum[0], lo_ff[B_W-1:1]};
         b_ff  <= b_ff >> 1;
      end
   end

   assign status.busy = busy;
   assign status.done = done_ff;
   assign product     = {hi_ff, lo_ff};

endmodule

@@ rtl/mcg_wave.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_wave
// waveform unit: quarter-wave sine rom, square, saw and triangle from phase
// ----------------------------------------------------------------------------
module mcg_wave #(
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                          clock,
   input  logic [mcg_pkg::PHASE_W-1:0]   phase,
   input  mcg_pkg::waveform_type         waveform,
   output logic signed [mcg_pkg::SAMPLE_W-1:0] wave
);

   localparam int IDX_W      = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int IDX_PROD_W = 30 + IDX_W;
   localparam int MAG_W      = mcg_pkg::WAVE_MAG_W;
   localparam int SW         = mcg_pkg::SAMPLE_W;
   localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(SINE_TABLE_DEPTH);

   // fixed-point taylor series, evaluated at elaboration for each entry
   function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        r;
      logic signed [63:0] acc;
      int                 n;
      x    = (64'(k) * mcg_pkg::PI_HALF_Q30) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      acc  = $signed(x);
      for (n = 1; n <= mcg_pkg::SINE_TERMS; n++) begin
         term = ((term * x2) >> 30) / mcg_pkg::TERM_DIV[n];
         if (n % 2 == 1) begin
            acc = acc - $signed(term);
         end else begin
            acc = acc + $signed(term);
         end
      end
      if (acc < 0) begin
         acc = '0;
      end
      r = ($unsigned(acc) * 64'd32767 + 64'd536870912) >> 30;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[MAG_W-1:0];
   endfunction

   logic [MAG_W-1:0] rom_w [0:SINE_TABLE_DEPTH];

   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
      localparam logic [MAG_W-1:0] ENTRY = quarter_sine(k);
      assign rom_w[k] = ENTRY;
   end

   logic [IDX_PROD_W-1:0]   idx_prod;
   logic [IDX_W-1:0]        idx;
   logic [IDX_W-1:0]        rom_addr;
   logic [MAG_W-1:0]        rom_data_ff;

   assign idx_prod = IDX_PROD_W'(phase[29:0]) * IDX_PROD_W'(SINE_TABLE_DEPTH);
   assign idx      = idx_prod[IDX_PROD_W-1:30];
   // odd quadrants read the table backwards
   assign rom_addr = phase[30] ? (DEPTH_IDX - idx) : idx;

   always_ff @(posedge clock) begin
      rom_data_ff <= rom_w[rom_addr];
   end

   logic signed [SW-1:0]    sine_pos;
   logic signed [SW-1:0]    full_pos;
   logic signed [47:0]      saw_ext;
   logic signed [47:0]      saw_t;
   logic [31:0]             tri_u;
   logic signed [31:0]      tri_c;
   logic [32:0]             tri_abs;
   logic signed [47:0]      tri_d;
   logic signed [47:0]      tri_t;
   logic signed [SW-1:0]    wave_in;
   logic signed [SW-1:0]    wave_ff;

   assign sine_pos = $signed({1'b0, rom_data_ff});
   assign full_pos = $signed({1'b0, mcg_pkg::FULL_SCALE});

   // saw: phase as signed, times 32767, floor by 2^31
   assign saw_ext = $signed({{16{phase[31]}}, phase});
   assign saw_t   = (saw_ext <<< 15) - saw_ext;

   // triangle: distance of the shifted phase from mid-scale, less a quarter
   assign tri_u   = phase - 32'h4000_0000;
   assign tri_c   = $signed({~tri_u[31], tri_u[30:0]});
   assign tri_abs = tri_c[31] ? (33'd0 - {1'b1, tri_c}) : {1'b0, tri_c};
   assign tri_d   = $signed({15'd0, tri_abs}) - 48'sh0000_4000_0000;
   assign tri_t   = (tri_d <<< 15) - tri_d;

   always_comb begin
      case (waveform)
         mcg_pkg::WAVE_SINE: begin
            wave_in = phase[31] ? -sine_pos : sine_pos;
         end
         mcg_pkg::WAVE_SQUARE: begin
            if (phase[30:0] == '0) begin
               wave_in = '0;
            end else begin
               wave_in = phase[31] ? -full_pos : full_pos;
            end
         end
         mcg_pkg::WAVE_SAW: begin
            wave_in = saw_t[46:31];
         end
         mcg_pkg::WAVE_TRIANGLE: begin
            wave_in = tri_t[45:30];
         end
         default: begin
            wave_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      wave_ff <= wave_in;
   end

   assign wave = wave_ff;

endmodule

@@ rtl/metronome_click_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// metronome_click_generator_unit
// metronome click sample generator with beat and measure counters
// ----------------------------------------------------------------------------
//  channel   direction  ports                       contents
//  req       in         req_tvalid/tready/tdata     tdata[0] restart
//  rsp       out        rsp_tvalid/tready/tdata     tdata sample, tuser accent,
//                       rsp_tuser/tlast             tlast measure_end
//  csr       in         csr_valid/ready/index/data  register writes
//
//  each sample walks rom, wave, gain multiply, scaling start, scaling multiply and
//  output, both multiplies on the bit-serial multiplier; requests wait for idle
//  reset is synchronous, active high; counters, phase and registers return to
//  their defaults, no clearing pass
//  a new request is taken while the previous result still waits on rsp; the
//  sequencer then holds at its last step until the output register frees up
// ----------------------------------------------------------------------------
module metronome_click_generator_unit #(
   parameter int COUNT_WIDTH      = 24,
   parameter int SINE_TABLE_DEPTH = 256,
   parameter int MAX_BEATS        = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [0] restart
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mcg_pkg::SAMPLE_W-1:0]        rsp_tdata,   // [15:0] sample
   output logic                                rsp_tuser,   // [0] accent
   output logic                                rsp_tlast,   // measure_end
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mcg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mcg_pkg::CSR_DATA_W-1:0]      csr_data
);

`include "metronome_click_generator_unit_macros.svh"

   localparam int BEAT_W      = $clog2(MAX_BEATS);
   localparam int MAXB_W      = $clog2(MAX_BEATS + 1);
   localparam int BEATS_CMP_W = ((MAXB_W > mcg_pkg::BEATS_CFG_W) ?
                                 MAXB_W : mcg_pkg::BEATS_CFG_W) + 1;
   localparam int CMP_W       = ((COUNT_WIDTH > mcg_pkg::LEN_CFG_W) ?
                                 COUNT_WIDTH : mcg_pkg::LEN_CFG_W) + 1;
   localparam int ENV_W       = CMP_W + 3;
   localparam int PW          = mcg_pkg::PHASE_W;
   localparam int GW          = mcg_pkg::GAIN_W;
   localparam int SW          = mcg_pkg::SAMPLE_W;
   localparam int MW          = mcg_pkg::WAVE_MAG_W;
   localparam int AW          = mcg_pkg::MUL_A_W;
   localparam int PRW         = mcg_pkg::MUL_P_W;

   // ---------------- configuration registers ----------------
   logic [mcg_pkg::BEATS_CFG_W-1:0]  beats_cfg_ff;
   logic [mcg_pkg::LEN_CFG_W-1:0]    beat_samples_ff;
   logic [mcg_pkg::LEN_CFG_W-1:0]    tone_samples_ff;
   mcg_pkg::waveform_type            waveform_ff;
   logic [PW-1:0]                    accent_step_ff;
   logic [PW-1:0]                    normal_step_ff;
   logic [GW-1:0]                    fade_in_ff;
   logic [GW-1:0]                    fade_out_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         beats_cfg_ff    <= mcg_pkg::RST_BEATS_PER_MEASURE;
         beat_samples_ff <= mcg_pkg::RST_BEAT_SAMPLES;
         tone_samples_ff <= mcg_pkg::RST_TONE_SAMPLES;
         waveform_ff     <= mcg_pkg::WAVE_SINE;
         accent_step_ff  <= mcg_pkg::RST_ACCENT_STEP;
         normal_step_ff  <= mcg_pkg::RST_NORMAL_STEP;
         fade_in_ff      <= mcg_pkg::RST_FADE_IN_GAIN;
         fade_out_ff     <= mcg_pkg::RST_FADE_OUT_GAIN;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mcg_pkg::CSR_BEATS_PER_MEASURE:
               beats_cfg_ff <= csr_data[mcg_pkg::BEATS_CFG_W-1:0];
            mcg_pkg::CSR_BEAT_SAMPLES:
               beat_samples_ff <= csr_data[mcg_pkg::LEN_CFG_W-1:0];
            mcg_pkg::CSR_TONE_SAMPLES:
               tone_samples_ff <= csr_data[mcg_pkg::LEN_CFG_W-1:0];
            mcg_pkg::CSR_WAVEFORM:
               waveform_ff <= mcg_pkg::waveform_type'(csr_data[1:0]);
            mcg_pkg::CSR_ACCENT_STEP:
               accent_step_ff <= csr_data[PW-1:0];
            mcg_pkg::CSR_NORMAL_STEP:
               normal_step_ff <= csr_data[PW-1:0];
            mcg_pkg::CSR_FADE_IN_GAIN:
               fade_in_ff <= csr_data[GW-1:0];
            mcg_pkg::CSR_FADE_OUT_GAIN:
               fade_out_ff <= csr_data[GW-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------- datapath units ----------------
   logic [PW-1:0]                    phase_ff;
   logic signed [SW-1:0]             wave;
   mcg_pkg::mul_cmd_type             mul_cmd;
   mcg_pkg::mul_status_type          mul_status;
   logic [PRW-1:0]                   product;

   mcg_wave #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_wave (
      .clock    (clock),
      .phase    (phase_ff),
      .waveform (waveform_ff),
      .wave     (wave)
   );

   mcg_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .status  (mul_status),
      .product (product)
   );

   // ---------------- envelope region ----------------
   logic [COUNT_WIDTH-1:0]           sample_idx_ff;
   logic [BEAT_W-1:0]                beat_ff;
   logic [ENV_W-1:0]                 env_i;
   logic [ENV_W-1:0]                 env_len;
   logic [ENV_W-1:0]                 env_i10;
   logic [ENV_W-1:0]                 env_i4;
   logic [ENV_W-1:0]                 env_len3;
   logic [ENV_W-1:0]                 env_fade_out_op;
   mcg_pkg::env_region_type          region_in;
   mcg_pkg::env_region_type          region_ff;
   logic [AW-1:0]                    env_op_in;
   logic [AW-1:0]                    env_op_ff;

   assign env_i           = ENV_W'(sample_idx_ff);
   assign env_len         = ENV_W'(tone_samples_ff);
   assign env_i10         = (env_i << 3) + (env_i << 1);
   assign env_i4          = env_i << 2;
   assign env_len3        = (env_len << 1) + env_len;
   assign env_fade_out_op = env_i4 - env_len3;

   always_comb begin
      if (env_i >= env_len) begin
         region_in = mcg_pkg::ENV_SILENT;
      end else if (env_i10 < env_len) begin
         region_in = mcg_pkg::ENV_FADE_IN;
      end else if (env_i4 > env_len3) begin
         region_in = mcg_pkg::ENV_FADE_OUT;
      end else begin
         region_in = mcg_pkg::ENV_FULL;
      end
      // inside the tone the index is below the 24-bit tone length
      if (region_in == mcg_pkg::ENV_FADE_IN) begin
         env_op_in = env_i[AW-1:0];
      end else begin
         env_op_in = env_fade_out_op[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      region_ff <= region_in;
      env_op_ff <= env_op_in;
   end

   // ---------------- gain from first multiply ----------------
   logic [PRW-3:0]                   fade_drop;
   logic [GW-1:0]                    gain_in;
   logic [GW-1:0]                    gain_ff;

   assign fade_drop = product[PRW-1:2];

   always_comb begin
      case (region_ff)
         mcg_pkg::ENV_SILENT: begin
            gain_in = '0;
         end
         mcg_pkg::ENV_FADE_IN: begin
            if (product > PRW'(mcg_pkg::ONE_Q24)) begin
               gain_in = mcg_pkg::ONE_Q24;
            end else begin
               gain_in = product[GW-1:0];
            end
         end
         mcg_pkg::ENV_FADE_OUT: begin
            if (fade_drop >= (PRW-2)'(mcg_pkg::ONE_Q24)) begin
               gain_in = '0;
            end else begin
               gain_in = mcg_pkg::ONE_Q24 - fade_drop[GW-1:0];
            end
         end
         default: begin
            gain_in = mcg_pkg::ONE_Q24;
         end
      endcase
   end

   // ---------------- result and counter update ----------------
   logic                             wave_neg;
   logic [MW-1:0]                    wave_abs;
   logic [SW-1:0]                    mag_ext;
   logic [SW-1:0]                    sample_val;
   logic [CMP_W-1:0]                 beat_len;
   logic [CMP_W-1:0]                 idx_next;
   logic [BEATS_CMP_W-1:0]           beats_lim;
   logic [BEATS_CMP_W-1:0]           beat_next;
   logic                             beat_done;
   logic                             measure_last;
   logic                             slot_free;

   assign wave_neg   = wave[SW-1];
   assign wave_abs   = wave_neg ? MW'(-wave) : wave[MW-1:0];
   assign mag_ext    = {1'b0, product[mcg_pkg::GAIN_FRAC_W +: MW]};
   assign sample_val = wave_neg ? (~mag_ext + SW'(1)) : mag_ext;

   assign beat_len  = (beat_samples_ff == '0) ? CMP_W'(1) : CMP_W'(beat_samples_ff);
   assign idx_next  = CMP_W'(sample_idx_ff) + CMP_W'(1);
   assign beat_done = (idx_next >= beat_len);

   always_comb begin
      if (beats_cfg_ff == '0) begin
         beats_lim = BEATS_CMP_W'(1);
      end else if (BEATS_CMP_W'(beats_cfg_ff) > BEATS_CMP_W'(MAX_BEATS)) begin
         beats_lim = BEATS_CMP_W'(MAX_BEATS);
      end else begin
         beats_lim = BEATS_CMP_W'(beats_cfg_ff);
      end
   end

   assign beat_next    = BEATS_CMP_W'(beat_ff) + BEATS_CMP_W'(1);
   assign measure_last = beat_done && (beat_next >= beats_lim);

   // ---------------- sequencer ----------------
   mcg_pkg::state_type               state_ff;
   mcg_pkg::state_type               state_in;
   logic [COUNT_WIDTH-1:0]           sample_idx_in;
   logic [BEAT_W-1:0]                beat_in;
   logic [PW-1:0]                    phase_in;
   logic                             gain_load;
   logic                             result_load;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [SW-1:0]                    rsp_sample_ff;
   logic                             rsp_accent_ff;
   logic                             rsp_last_ff;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == mcg_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      sample_idx_in = sample_idx_ff;
      beat_in       = beat_ff;
      phase_in      = phase_ff;
      gain_load     = 1'b0;
      result_load   = 1'b0;
      mul_cmd.start = 1'b0;
      mul_cmd.a     = env_op_ff;
      mul_cmd.b     = (region_ff == mcg_pkg::ENV_FADE_IN) ? fade_in_ff : fade_out_ff;
      case (state_ff)
         mcg_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tdata[0]) begin
                  sample_idx_in = '0;
                  beat_in       = '0;
                  phase_in      = '0;
               end
               state_in = mcg_pkg::ST_ROM;
            end
         end
         mcg_pkg::ST_ROM: begin
            state_in = mcg_pkg::ST_WAVE;
         end
         mcg_pkg::ST_WAVE: begin
            mul_cmd.start = 1'b1;
            state_in      = mcg_pkg::ST_GAIN_MUL;
         end
         mcg_pkg::ST_GAIN_MUL: begin
            if (mul_status.done) begin
               gain_load = 1'b1;
               state_in  = mcg_pkg::ST_MAG_START;
            end
         end
         mcg_pkg::ST_MAG_START: begin
            mul_cmd.start = 1'b1;
            mul_cmd.a     = AW'(wave_abs);
            mul_cmd.b     = gain_ff;
            state_in      = mcg_pkg::ST_MAG_MUL;
         end
         mcg_pkg::ST_MAG_MUL: begin
            if (mul_status.done) begin
               state_in = mcg_pkg::ST_OUTPUT;
            end
         end
         mcg_pkg::ST_OUTPUT: begin
            if (slot_free) begin
               result_load = 1'b1;
               state_in    = mcg_pkg::ST_IDLE;
               if (beat_done) begin
                  sample_idx_in = '0;
                  phase_in      = '0;
                  beat_in       = measure_last ? '0 : beat_next[BEAT_W-1:0];
               end else begin
                  sample_idx_in = idx_next[COUNT_WIDTH-1:0];
                  phase_in      = phase_ff +
                                  ((beat_ff == '0) ? accent_step_ff : normal_step_ff);
               end
            end
         end
         default: begin
            state_in = mcg_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = result_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mcg_pkg::ST_IDLE;
         sample_idx_ff <= '0;
         beat_ff       <= '0;
         phase_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sample_idx_ff <= sample_idx_in;
         beat_ff       <= beat_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (gain_load) begin
         gain_ff <= gain_in;
      end
      if (result_load) begin
         rsp_sample_ff <= sample_val;
         rsp_accent_ff <= (beat_ff == '0);
         rsp_last_ff   <= measure_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sample_ff;
   assign rsp_tuser  = rsp_accent_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- assertions ----------------
   `MCG_ASSERT_SAME(a_mul_idle_at_start, clock, reset, mul_cmd.start, !mul_status.busy)
   `MCG_ASSERT_NEXT(a_result_after_commit, clock, reset, result_load, (rsp_tvalid && (state_ff == mcg_pkg::ST_IDLE)))
   `MCG_ASSERT_SAME(a_gain_bounded, clock, reset, (state_ff == mcg_pkg::ST_MAG_MUL), (gain_ff <= mcg_pkg::ONE_Q24))
   `MCG_ASSERT_SAME(a_beat_in_range, clock, reset, 1'b1, (beat_ff < MAX_BEATS))

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for metronome_click_generator_unit: a queue-fed driver
// sends restart flags, a bit-exact click model predicts each sample, accent
// and measure-end flag, and a monitor compares every result transfer in order
// while the register setup changes between phases and both sides stall
// ----------------------------------------------------------------------------
module tb;
   import mcg_pkg::*;

   localparam int TABLE_DEPTH = 256;
   localparam int BEATS_MAX   = 32;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 150;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       accent;
      logic                       measure_end;
   } click_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = 8'd0;   // [0] restart
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_tdata;          // [15:0] sample
   logic                   rsp_tuser;          // [0] accent
   logic                   rsp_tlast;          // measure_end
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   metronome_click_generator_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // click model: register copy and counters
   logic [BEATS_CFG_W-1:0] cfg_beats;
   logic [LEN_CFG_W-1:0]   cfg_beat_len;
   logic [LEN_CFG_W-1:0]   cfg_tone_len;
   waveform_type           cfg_wave;
   logic [PHASE_W-1:0]     cfg_accent_step;
   logic [PHASE_W-1:0]     cfg_normal_step;
   logic [GAIN_W-1:0]      cfg_fade_in;
   logic [GAIN_W-1:0]      cfg_fade_out;

   logic [LEN_CFG_W-1:0]   pos_in_beat;
   logic [4:0]             beat_idx;
   logic [PHASE_W-1:0]     phase_acc;

   int sine_quarter_tbl [0:TABLE_DEPTH];

   bit     restart_queue [$];
   click_t expected_clicks [$];
   int     errors = 0;
   int     send_idle_pct = 0;
   int     recv_stall_pct = 0;
   int     idle_cycles = 0;

   // taylor series of sin over the quarter wave, Q30
   function automatic int quarter_sine(int k);
      longint unsigned x, x2, term, r;
      longint          sum;
      x = (longint'(k) * PI_HALF_Q30) / TABLE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int n = 1; n <= 13; n++) begin
         term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
         if (n % 2 == 1) sum -= term;
         else sum += term;
      end
      if (sum < 0) sum = 0;
      r = sum;
      r = (r * 32767 + 64'd536870912) >> 30;
      return (r > 32767) ? 32767 : int'(r);
   endfunction

   function automatic longint wave_level(logic [PHASE_W-1:0] p);
      logic [1:0]         quad;
      int                 idx;
      int                 v;
      logic [PHASE_W-1:0] u;
      longint             s;
      case (cfg_wave)
         WAVE_SINE: begin
            quad = p[31:30];
            // table index is the top 8 bits of the phase within the quadrant
            idx = p[29:22];
            v = quad[0] ? sine_quarter_tbl[TABLE_DEPTH - idx] : sine_quarter_tbl[idx];
            return quad[1] ? -v : v;
         end
         WAVE_SQUARE: begin
            if (p == 32'h0 || p == 32'h8000_0000) return 0;
            return p[31] ? -32767 : 32767;
         end
         WAVE_SAW: begin
            u = p + 32'h8000_0000;
            s = longint'({32'd0, u}) - 64'sd2147483648;
            return (s * 32767) >>> 31;
         end
         default: begin
            u = p - 32'h4000_0000;
            s = longint'({32'd0, u}) - 64'sd2147483648;
            if (s < 0) s = -s;
            s = s - 64'sd1073741824;
            return (s * 32767) >>> 30;
         end
      endcase
   endfunction

   function automatic longint unsigned click_gain(longint unsigned i);
      longint unsigned len, g, drop;
      len = cfg_tone_len;
      if (i >= len) return 0;
      if (i * 10 < len) begin
         g = i * cfg_fade_in;
      end else if (i * 4 > len * 3) begin
         drop = ((i * 4 - len * 3) * cfg_fade_out) >> 2;
         g = (drop >= ONE_Q24) ? 0 : ONE_Q24 - drop;
      end else begin
         g = ONE_Q24;
      end
      return (g > ONE_Q24) ? ONE_Q24 : g;
   endfunction

   function automatic click_t predict_click(logic restart);
      click_t          r;
      int              beats;
      longint unsigned blen, i, g, mag, wmag;
      longint          w, smp;
      bit              beat_done, last;
      beats = cfg_beats;
      if (beats == 0) beats = 1;
      if (beats > BEATS_MAX) beats = BEATS_MAX;
      blen = (cfg_beat_len == 0) ? 1 : cfg_beat_len;
      if (restart) begin
         pos_in_beat = '0;
         beat_idx = '0;
         phase_acc = '0;
      end
      i = pos_in_beat;
      w = wave_level(phase_acc);
      g = click_gain(i);
      wmag = (w < 0) ? -w : w;
      mag = (wmag * g) >> 24;
      smp = (w < 0) ? -longint'(mag) : longint'(mag);
      beat_done = (i + 1 >= blen);
      last = beat_done && (int'(beat_idx) + 1 >= beats);
      r.sample = 16'(smp);
      r.accent = (beat_idx == 0);
      r.measure_end = last;
      if (beat_done) begin
         pos_in_beat = '0;
         phase_acc = '0;
         beat_idx = last ? 5'd0 : beat_idx + 5'd1;
      end else begin
         phase_acc = phase_acc + ((beat_idx == 0) ? cfg_accent_step : cfg_normal_step);
         pos_in_beat = pos_in_beat + 1'b1;
      end
      return r;
   endfunction

   // sender: one transfer per accepted restart flag
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_clicks.push_back(predict_click(req_tdata[0]));
         if (!req_tvalid || req_tready) begin
            if (restart_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= {7'd0, restart_queue.pop_front()};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: random backpressure and in-order compare
   always @(posedge clock) begin : rsp_monitor
      click_t want;
      rsp_tready <= reset ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_clicks.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got sample %0d accent %0b end %0b",
                     $time, $signed(rsp_tdata), rsp_tuser, rsp_tlast);
         end else begin
            want = expected_clicks.pop_front();
            if (rsp_tdata !== want.sample) begin
               errors++;
               $display("%0t: sample mismatch, expected %0d, got %0d",
                        $time, want.sample, $signed(rsp_tdata));
            end
            if (rsp_tuser !== want.accent) begin
               errors++;
               $display("%0t: accent mismatch, expected %0b, got %0b",
                        $time, want.accent, rsp_tuser);
            end
            if (rsp_tlast !== want.measure_end) begin
               errors++;
               $display("%0t: measure end mismatch, expected %0b, got %0b",
                        $time, want.measure_end, rsp_tlast);
            end
         end
      end
   end

   // watchdog on cycles with no transfer anywhere
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic cfg_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_BEATS_PER_MEASURE: cfg_beats = data[BEATS_CFG_W-1:0];
         CSR_BEAT_SAMPLES:      cfg_beat_len = data[LEN_CFG_W-1:0];
         CSR_TONE_SAMPLES:      cfg_tone_len = data[LEN_CFG_W-1:0];
         CSR_WAVEFORM:          cfg_wave = waveform_type'(data[1:0]);
         CSR_ACCENT_STEP:       cfg_accent_step = data;
         CSR_NORMAL_STEP:       cfg_normal_step = data;
         CSR_FADE_IN_GAIN:      cfg_fade_in = data[GAIN_W-1:0];
         default:               cfg_fade_out = data[GAIN_W-1:0];
      endcase
   endtask

   // queue a run of samples and wait until every result has been taken
   task automatic run_items(int count, bit first_restart, bit random_restarts);
      for (int k = 0; k < count; k++) begin
         if (k == 0) restart_queue.push_back(first_restart);
         else restart_queue.push_back(random_restarts && $urandom_range(0, 31) == 0);
      end
      do @(posedge clock);
      while (restart_queue.size() != 0 || expected_clicks.size() != 0 || req_tvalid);
   endtask

   // random bits above the register width, which the block drops
   function automatic logic [31:0] with_junk(logic [31:0] v, int w);
      return v | ($urandom() << w);
   endfunction

   initial begin : stimulus
      int              bl, tl;
      longint unsigned fin, fout;

      for (int k = 0; k <= TABLE_DEPTH; k++) sine_quarter_tbl[k] = quarter_sine(k);
      cfg_beats = RST_BEATS_PER_MEASURE;
      cfg_beat_len = RST_BEAT_SAMPLES;
      cfg_tone_len = RST_TONE_SAMPLES;
      cfg_wave = WAVE_SINE;
      cfg_accent_step = RST_ACCENT_STEP;
      cfg_normal_step = RST_NORMAL_STEP;
      cfg_fade_in = RST_FADE_IN_GAIN;
      cfg_fade_out = RST_FADE_OUT_GAIN;
      pos_in_beat = '0;
      beat_idx = '0;
      phase_acc = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // defaults out of reset
      run_items(3, 1'b1, 1'b0);

      // zero beats, zero beat length, zero tone length
      cfg_write(CSR_BEATS_PER_MEASURE, 32'd0);
      cfg_write(CSR_BEAT_SAMPLES, 32'd0);
      cfg_write(CSR_TONE_SAMPLES, 32'd0);
      cfg_write(CSR_WAVEFORM, 32'(WAVE_SQUARE));
      cfg_write(CSR_ACCENT_STEP, 32'd0);
      cfg_write(CSR_NORMAL_STEP, 32'hFFFF_FFFF);
      cfg_write(CSR_FADE_IN_GAIN, 32'h1FF_FFFF);
      cfg_write(CSR_FADE_OUT_GAIN, 32'd0);
      run_items(2, 1'b0, 1'b0);

      // more beats than the block holds, longest tone, fade-in saturating
      cfg_write(CSR_BEATS_PER_MEASURE, 32'd33);
      cfg_write(CSR_BEAT_SAMPLES, 32'd4);
      cfg_write(CSR_TONE_SAMPLES, 32'hFF_FFFF);
      cfg_write(CSR_WAVEFORM, 32'(WAVE_SAW));
      cfg_write(CSR_ACCENT_STEP, 32'h8000_0000);
      cfg_write(CSR_NORMAL_STEP, 32'h4000_0000);
      cfg_write(CSR_FADE_IN_GAIN, 32'(ONE_Q24));
      cfg_write(CSR_FADE_OUT_GAIN, 32'h1FF_FFFF);
      run_items(4, 1'b1, 1'b0);

      // walk into beat 4, lengthen the beat, then shrink both counters under it
      cfg_write(CSR_BEATS_PER_MEASURE, 32'd8);
      cfg_write(CSR_BEAT_SAMPLES, 32'd2);
      cfg_write(CSR_TONE_SAMPLES, 32'd2);
      cfg_write(CSR_WAVEFORM, 32'(WAVE_TRIANGLE));
      run_items(8, 1'b1, 1'b0);
      cfg_write(CSR_BEAT_SAMPLES, 32'd40);
      cfg_write(CSR_TONE_SAMPLES, 32'd30);
      cfg_write(CSR_NORMAL_STEP, $urandom());
      run_items(4, 1'b0, 1'b0);
      cfg_write(CSR_BEATS_PER_MEASURE, 32'd2);
      cfg_write(CSR_BEAT_SAMPLES, 32'd3);
      run_items(3, 1'b0, 1'b0);

      // random phases; restarts only at random, so setups can change mid-beat
      for (int ph = 0; ph < 16; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase

         bl = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 0) ? 0 : 24'hFF_FFFF)
                                          : $urandom_range(1, 48);
         case ($urandom_range(0, 7))
            0:       tl = 0;
            1:       tl = 1;
            2:       tl = 24'hFF_FFFF;
            default: tl = $urandom_range(2, (bl > 0 && bl < 48) ? bl + 8 : 56);
         endcase
         fin = (tl == 0) ? $urandom_range(0, 32'h1FF_FFFF) : (64'd10 << 24) / tl;
         fout = (tl == 0) ? $urandom_range(0, 32'h1FF_FFFF) : (64'd4 << 24) / tl;
         if (fin > 32'h1FF_FFFF) fin = 32'h1FF_FFFF;
         if ($urandom_range(0, 4) == 0) fin = $urandom_range(0, 32'h1FF_FFFF);
         if ($urandom_range(0, 4) == 0) fout = $urandom_range(0, 32'h1FF_FFFF);

         if ($urandom_range(0, 3) != 0)
            cfg_write(CSR_BEATS_PER_MEASURE,
                      with_junk(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                            : $urandom_range(1, 6),
                                BEATS_CFG_W));
         if ($urandom_range(0, 3) != 0) cfg_write(CSR_BEAT_SAMPLES, with_junk(bl, LEN_CFG_W));
         if ($urandom_range(0, 3) != 0) cfg_write(CSR_TONE_SAMPLES, with_junk(tl, LEN_CFG_W));
         if ($urandom_range(0, 3) != 0) cfg_write(CSR_WAVEFORM, $urandom());
         if ($urandom_range(0, 3) != 0) cfg_write(CSR_ACCENT_STEP, $urandom());
         if ($urandom_range(0, 3) != 0)
            cfg_write(CSR_NORMAL_STEP, ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom());
         if ($urandom_range(0, 3) != 0) cfg_write(CSR_FADE_IN_GAIN, with_junk(fin, GAIN_W));
         if ($urandom_range(0, 3) != 0) cfg_write(CSR_FADE_OUT_GAIN, with_junk(fout, GAIN_W));

         run_items($urandom_range(60, 130), $urandom_range(0, 3) == 0, 1'b1);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_clicks.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

@@ metronome_click_generator_unit.f @@
+incdir+rtl
rtl/mcg_pkg.sv
rtl/mcg_serial_mul.sv
rtl/mcg_wave.sv
rtl/metronome_click_generator_unit.sv
test/tb.sv
